FILE: hdl/bmg_pkg.sv
package bmg_pkg;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_STEP    = 2'd0;
   localparam opcode_type OP_READ    = 2'd1;
   localparam opcode_type OP_RESTART = 2'd2;

   typedef logic [1:0] dir_type;

   localparam dir_type DIR_EAST  = 2'd0;
   localparam dir_type DIR_WEST  = 2'd1;
   localparam dir_type DIR_SOUTH = 2'd2;
   localparam dir_type DIR_NORTH = 2'd3;

   // bit positions of the walls inside a cell word
   typedef logic [1:0] wall_type;

   localparam wall_type WALL_TOP    = 2'd0;
   localparam wall_type WALL_BOTTOM = 2'd1;
   localparam wall_type WALL_LEFT   = 2'd2;
   localparam wall_type WALL_RIGHT  = 2'd3;

   // cell word: visited mark above the four wall bits
   typedef logic [4:0] word_type;

   localparam int         WORD_VIS  = 4;
   localparam logic [3:0] WALLS_ALL = 4'hF;

endpackage

FILE: hdl/backtracking_maze_generator.sv
// A read, a no-op or a step after the maze is finished reads the cell memory and then registers
// its result; a generation step first does four neighbor reads of the cell memory through its
// single read port, then the wall read-modify-writes when it moves; restart first sweeps the memory.
// Throughput: one item at a time; the next item is taken the cycle after a result is registered.
// Reset: synchronous; the cell memory is then swept, one entry a cycle, over all 2^AW entries
// (AW = clog2(GRID_WIDTH) + clog2(GRID_HEIGHT), 256 by default), with req_ready low.
module backtracking_maze_generator #(
   parameter int GRID_WIDTH  = 16,
   parameter int GRID_HEIGHT = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bmg_pkg::opcode_type  req_opcode,
   input  logic [1:0]           req_rand_dir,
   input  logic [3:0]           req_cell_x,
   input  logic [3:0]           req_cell_y,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [3:0]           rsp_pos_x,
   output logic [3:0]           rsp_pos_y,
   output logic                 rsp_finished,
   output logic                 rsp_wall_top,
   output logic                 rsp_wall_bottom,
   output logic                 rsp_wall_left,
   output logic                 rsp_wall_right,
   output logic                 rsp_cell_visited
);
   import bmg_pkg::*;

   localparam int XW         = $clog2(GRID_WIDTH);
   localparam int YW         = $clog2(GRID_HEIGHT);
   localparam int AW         = XW + YW;
   localparam int MEM_DEPTH  = 1 << AW;
   localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
   localparam int SPW        = $clog2(CELL_COUNT + 1);
   localparam int SIW        = $clog2(CELL_COUNT);

   localparam logic [AW-1:0] GAP_TOP    = {YW'(0), XW'(GRID_WIDTH / 2)};
   localparam logic [AW-1:0] GAP_BOTTOM = {YW'(GRID_HEIGHT - 1), XW'(GRID_WIDTH / 2)};
   localparam logic [AW-1:0] GAP_LEFT   = {YW'(GRID_HEIGHT / 2), XW'(0)};
   localparam logic [AW-1:0] GAP_RIGHT  = {YW'(GRID_HEIGHT / 2), XW'(GRID_WIDTH - 1)};

   localparam logic [2:0] NB_LAST = 3'd4;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CLEAR    = 4'd1;
   localparam logic [3:0] S_NB       = 4'd2;
   localparam logic [3:0] S_DECIDE   = 4'd3;
   localparam logic [3:0] S_MV_HERE  = 4'd4;
   localparam logic [3:0] S_MV_THERE = 4'd5;
   localparam logic [3:0] S_POP      = 4'd6;
   localparam logic [3:0] S_JMP      = 4'd7;
   localparam logic [3:0] S_GAP_RD   = 4'd8;
   localparam logic [3:0] S_GAP_WR   = 4'd9;
   localparam logic [3:0] S_READ     = 4'd10;
   localparam logic [3:0] S_RSP      = 4'd11;

   // control state
   logic [3:0]     state_ff, state_in;
   logic [XW-1:0]  cur_x_ff, cur_x_in;
   logic [YW-1:0]  cur_y_ff, cur_y_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [SPW-1:0] vc_ff, vc_in;
   logic           done_ff, done_in;
   logic           item_ff, item_in;
   logic [AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // item and scan registers
   opcode_type     op_ff, op_in;
   dir_type        dir_ff, dir_in;
   logic [XW-1:0]  jx_ff, jx_in;
   logic [YW-1:0]  jy_ff, jy_in;
   logic           jin_ff, jin_in;
   logic [3:0]     open_ff, open_in;
   logic [2:0]     nb_cnt_ff, nb_cnt_in;
   wall_type       gap_cnt_ff, gap_cnt_in;

   // result registers
   logic [3:0]     rsp_pos_x_ff, rsp_pos_y_ff;
   logic           rsp_finished_ff, rsp_cell_visited_ff;
   logic [3:0]     rsp_walls_ff;
   logic           load_rsp;

   // cell memory
   word_type       cell_mem [MEM_DEPTH];
   word_type       rd_ff;
   logic           rd_en, wr_en;
   logic [AW-1:0]  rd_addr, wr_addr;
   word_type       wr_data;

   // backtrack stack memory
   logic [AW-1:0]  stack_mem [CELL_COUNT];
   logic [AW-1:0]  stk_rd_ff;
   logic           stk_we, stk_re;
   logic [SIW-1:0] stk_waddr, stk_raddr;

   logic [AW-1:0]  cur_addr, j_addr, tgt_addr, gap_addr;
   logic [AW-1:0]  nb_addr [4];
   logic [3:0]     nb_in;
   logic [SPW-1:0] sp_m1;
   logic [1:0]     nb_prev;
   logic           req_in_grid;
   wall_type       here_bit, there_bit;

   assign cur_addr    = {cur_y_ff, cur_x_ff};
   assign j_addr      = {jy_ff, jx_ff};
   assign sp_m1       = sp_ff - SPW'(1);
   assign nb_prev     = 2'(nb_cnt_ff - 3'd1);
   assign tgt_addr    = nb_addr[dir_ff];
   assign stk_waddr   = sp_ff[SIW-1:0];
   assign stk_raddr   = sp_m1[SIW-1:0];
   assign req_in_grid = (32'(req_cell_x) < GRID_WIDTH) && (32'(req_cell_y) < GRID_HEIGHT);

   // neighbors in east, west, south, north order
   always_comb begin
      nb_in[0]   = cur_x_ff != XW'(GRID_WIDTH - 1);
      nb_addr[0] = {cur_y_ff, cur_x_ff + XW'(1)};
      nb_in[1]   = cur_x_ff != '0;
      nb_addr[1] = {cur_y_ff, cur_x_ff - XW'(1)};
      nb_in[2]   = cur_y_ff != YW'(GRID_HEIGHT - 1);
      nb_addr[2] = {cur_y_ff + YW'(1), cur_x_ff};
      nb_in[3]   = cur_y_ff != '0;
      nb_addr[3] = {cur_y_ff - YW'(1), cur_x_ff};
   end

   always_comb begin
      case (dir_ff)
         DIR_EAST: begin
            here_bit  = WALL_RIGHT;
            there_bit = WALL_LEFT;
         end
         DIR_WEST: begin
            here_bit  = WALL_LEFT;
            there_bit = WALL_RIGHT;
         end
         DIR_SOUTH: begin
            here_bit  = WALL_BOTTOM;
            there_bit = WALL_TOP;
         end
         default: begin
            here_bit  = WALL_TOP;
            there_bit = WALL_BOTTOM;
         end
      endcase
   end

   always_comb begin
      case (gap_cnt_ff)
         WALL_TOP:    gap_addr = GAP_TOP;
         WALL_BOTTOM: gap_addr = GAP_BOTTOM;
         WALL_LEFT:   gap_addr = GAP_LEFT;
         default:     gap_addr = GAP_RIGHT;
      endcase
   end

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in     = state_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      sp_in        = sp_ff;
      vc_in        = vc_ff;
      done_in      = done_ff;
      item_in      = item_ff;
      clr_cnt_in   = clr_cnt_ff;
      op_in        = op_ff;
      dir_in       = dir_ff;
      jx_in        = jx_ff;
      jy_in        = jy_ff;
      jin_in       = jin_ff;
      open_in      = open_ff;
      nb_cnt_in    = nb_cnt_ff;
      gap_cnt_in   = gap_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      load_rsp     = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = cur_addr;
      wr_en        = 1'b0;
      wr_addr      = cur_addr;
      wr_data      = rd_ff;
      stk_we       = 1'b0;
      stk_re       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_opcode;
               dir_in  = req_rand_dir;
               jx_in   = XW'(req_cell_x);
               jy_in   = YW'(req_cell_y);
               jin_in  = req_in_grid;
               item_in = 1'b1;
               if (req_opcode == OP_RESTART) begin
                  cur_x_in   = req_in_grid ? XW'(req_cell_x) : '0;
                  cur_y_in   = req_in_grid ? YW'(req_cell_y) : '0;
                  sp_in      = '0;
                  vc_in      = SPW'(1);
                  done_in    = 1'b0;
                  clr_cnt_in = '0;
                  state_in   = S_CLEAR;
               end else if (req_opcode == OP_STEP && !done_ff) begin
                  if (vc_ff == SPW'(CELL_COUNT)) begin
                     done_in    = 1'b1;
                     gap_cnt_in = WALL_TOP;
                     state_in   = S_GAP_RD;
                  end else begin
                     nb_cnt_in = '0;
                     state_in  = S_NB;
                  end
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = {clr_cnt_ff == cur_addr, WALLS_ALL};
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == '1) begin
               state_in = item_ff ? S_READ : S_IDLE;
            end
         end
         S_NB: begin
            // read one neighbor a cycle, capture the previous one
            if (nb_cnt_ff != NB_LAST) begin
               rd_en   = 1'b1;
               rd_addr = nb_addr[nb_cnt_ff[1:0]];
            end
            if (nb_cnt_ff != '0) begin
               open_in[nb_prev] = nb_in[nb_prev] && !rd_ff[WORD_VIS];
            end
            nb_cnt_in = nb_cnt_ff + 3'd1;
            if (nb_cnt_ff == NB_LAST) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (open_ff != '0) begin
               if (open_ff[dir_ff]) begin
                  if (sp_ff != SPW'(CELL_COUNT)) begin
                     stk_we = 1'b1;
                     sp_in  = sp_ff + SPW'(1);
                  end
                  rd_en    = 1'b1;
                  rd_addr  = cur_addr;
                  state_in = S_MV_HERE;
               end else begin
                  state_in = S_READ;
               end
            end else if (sp_ff != '0) begin
               sp_in    = sp_m1;
               stk_re   = 1'b1;
               state_in = S_POP;
            end else if (jin_ff) begin
               rd_en    = 1'b1;
               rd_addr  = j_addr;
               state_in = S_JMP;
            end else begin
               state_in = S_READ;
            end
         end
         S_MV_HERE: begin
            wr_en             = 1'b1;
            wr_addr           = cur_addr;
            wr_data[here_bit] = 1'b0;
            rd_en             = 1'b1;
            rd_addr           = tgt_addr;
            state_in          = S_MV_THERE;
         end
         S_MV_THERE: begin
            wr_en              = 1'b1;
            wr_addr            = tgt_addr;
            wr_data[there_bit] = 1'b0;
            wr_data[WORD_VIS]  = 1'b1;
            cur_x_in           = tgt_addr[XW-1:0];
            cur_y_in           = tgt_addr[AW-1:XW];
            vc_in              = vc_ff + SPW'(1);
            state_in           = S_READ;
         end
         S_POP: begin
            cur_x_in = stk_rd_ff[XW-1:0];
            cur_y_in = stk_rd_ff[AW-1:XW];
            state_in = S_READ;
         end
         S_JMP: begin
            if (!rd_ff[WORD_VIS]) begin
               wr_en             = 1'b1;
               wr_addr           = j_addr;
               wr_data[WORD_VIS] = 1'b1;
               cur_x_in          = jx_ff;
               cur_y_in          = jy_ff;
               vc_in             = vc_ff + SPW'(1);
            end
            state_in = S_READ;
         end
         S_GAP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = gap_addr;
            state_in = S_GAP_WR;
         end
         S_GAP_WR: begin
            wr_en               = 1'b1;
            wr_addr             = gap_addr;
            wr_data[gap_cnt_ff] = 1'b0;
            gap_cnt_in          = gap_cnt_ff + 2'd1;
            state_in            = (gap_cnt_ff == WALL_RIGHT) ? S_READ : S_GAP_RD;
         end
         S_READ: begin
            rd_en    = 1'b1;
            rd_addr  = (op_ff == OP_READ) ? j_addr : cur_addr;
            state_in = S_RSP;
         end
         S_RSP: begin
            // hold until the previous result has been transferred
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               item_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         sp_ff        <= '0;
         vc_ff        <= SPW'(1);
         done_ff      <= 1'b0;
         item_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         sp_ff        <= sp_in;
         vc_ff        <= vc_in;
         done_ff      <= done_in;
         item_ff      <= item_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      dir_ff     <= dir_in;
      jx_ff      <= jx_in;
      jy_ff      <= jy_in;
      jin_ff     <= jin_in;
      open_ff    <= open_in;
      nb_cnt_ff  <= nb_cnt_in;
      gap_cnt_ff <= gap_cnt_in;
      if (load_rsp) begin
         rsp_pos_x_ff    <= 4'(cur_x_ff);
         rsp_pos_y_ff    <= 4'(cur_y_ff);
         rsp_finished_ff <= done_ff;
         if (op_ff == OP_READ && !jin_ff) begin
            rsp_walls_ff        <= WALLS_ALL;
            rsp_cell_visited_ff <= 1'b1;
         end else begin
            rsp_walls_ff        <= rd_ff[3:0];
            rsp_cell_visited_ff <= rd_ff[WORD_VIS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= cell_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= cur_addr;
      end
      if (stk_re) begin
         stk_rd_ff <= stack_mem[stk_raddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = rsp_pos_x_ff;
   assign rsp_pos_y        = rsp_pos_y_ff;
   assign rsp_finished     = rsp_finished_ff;
   assign rsp_wall_top     = rsp_walls_ff[WALL_TOP];
   assign rsp_wall_bottom  = rsp_walls_ff[WALL_BOTTOM];
   assign rsp_wall_left    = rsp_walls_ff[WALL_LEFT];
   assign rsp_wall_right   = rsp_walls_ff[WALL_RIGHT];
   assign rsp_cell_visited = rsp_cell_visited_ff;

endmodule

FILE: hdl/bmg_checker.sv
module bmg_checker #(
   parameter int GRID_WIDTH  = 16,
   parameter int GRID_HEIGHT = 16
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input bmg_pkg::opcode_type req_opcode,
   input logic [3:0]          req_cell_x,
   input logic [3:0]          req_cell_y,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [3:0]          rsp_pos_x,
   input logic [3:0]          rsp_pos_y,
   input logic                rsp_finished,
   input logic                rsp_wall_top,
   input logic                rsp_wall_bottom,
   input logic                rsp_wall_left,
   input logic                rsp_wall_right,
   input logic                rsp_cell_visited
);
   import bmg_pkg::*;

   opcode_type last_op_ff;
   logic       last_oob_ff;
   logic       stalled_ff;
   logic       new_rsp;
   logic       all_solid;

   // remember the item in flight: only one is taken at a time
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         last_op_ff  <= req_opcode;
         last_oob_ff <= !((32'(req_cell_x) < GRID_WIDTH) && (32'(req_cell_y) < GRID_HEIGHT));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stalled_ff <= 1'b0;
      end else begin
         stalled_ff <= rsp_valid && !rsp_ready;
      end
   end

   assign new_rsp   = rsp_valid && !stalled_ff;
   assign all_solid = rsp_wall_top && rsp_wall_bottom && rsp_wall_left && rsp_wall_right
                      && rsp_cell_visited;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
                                  && $stable(rsp_cell_visited))
      else $error("result changed while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in flight");

   a_current_visited: assert property (@(posedge clock) disable iff (reset)
      new_rsp && last_op_ff != OP_READ |-> rsp_cell_visited)
      else $error("current cell reported as unvisited");

   a_restart_fresh: assert property (@(posedge clock) disable iff (reset)
      new_rsp && last_op_ff == OP_RESTART |-> !rsp_finished && all_solid)
      else $error("restart result does not show a fresh start cell");

   a_read_outside: assert property (@(posedge clock) disable iff (reset)
      new_rsp && last_op_ff == OP_READ && last_oob_ff |-> all_solid)
      else $error("read outside the grid not reported as solid");

endmodule

bind backtracking_maze_generator bmg_checker #(
   .GRID_WIDTH  (GRID_WIDTH),
   .GRID_HEIGHT (GRID_HEIGHT)
) u_bmg_checker (.*);

FILE: tb/sv/tb_backtracking_maze_generator.sv
module tb_backtracking_maze_generator;
   timeunit 1ns;
   timeprecision 1ps;

   import bmg_pkg::*;

   localparam int GW       = 16;
   localparam int GH       = 16;
   localparam int CELLS    = GW * GH;
   localparam int ITEMS    = 1800;
   localparam int TAIL     = 200;
   localparam int WATCHDOG = 4000;
   localparam int DRAIN    = 20;
   localparam int MAX_SHOWN = 10;

   // the fourth opcode value has no function in the block
   localparam opcode_type OP_NONE = 2'd3;

   typedef struct packed {
      opcode_type op;
      dir_type    dir;
      logic [3:0] x;
      logic [3:0] y;
   } maze_req_type;

   typedef struct packed {
      logic [3:0] pos_x;
      logic [3:0] pos_y;
      logic       finished;
      logic       top;
      logic       bottom;
      logic       left;
      logic       right;
      logic       visited;
   } maze_rsp_type;

   typedef struct packed {
      logic [CELLS-1:0][3:0] walls;
      logic [CELLS-1:0]      seen;
      logic [CELLS-1:0][7:0] stack;
      logic [8:0]            sp;
      logic [3:0]            cx;
      logic [3:0]            cy;
      logic [8:0]            count;
      logic                  done;
   } maze_state_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   opcode_type req_opcode = OP_STEP;
   logic [1:0] req_rand_dir = '0;
   logic [3:0] req_cell_x = '0;
   logic [3:0] req_cell_y = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [3:0] rsp_pos_x;
   logic [3:0] rsp_pos_y;
   logic       rsp_finished;
   logic       rsp_wall_top;
   logic       rsp_wall_bottom;
   logic       rsp_wall_left;
   logic       rsp_wall_right;
   logic       rsp_cell_visited;

   maze_req_type   pend_items[$];
   maze_rsp_type   want_q[$];
   maze_state_type plan;
   maze_state_type model;
   int          total_items = 0;
   int          n_sent = 0;
   int          n_accepted = 0;
   int          errors = 0;
   int          stall_cycles = 0;
   int          send_gap = 0;
   int          rsp_gap = 0;
   logic        req_taken = 1'b0;

   backtracking_maze_generator #(
      .GRID_WIDTH (GW),
      .GRID_HEIGHT(GH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_rand_dir    (req_rand_dir),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_finished    (rsp_finished),
      .rsp_wall_top    (rsp_wall_top),
      .rsp_wall_bottom (rsp_wall_bottom),
      .rsp_wall_left   (rsp_wall_left),
      .rsp_wall_right  (rsp_wall_right),
      .rsp_cell_visited(rsp_cell_visited)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int cell_at(int x, int y);
      return y * GW + x;
   endfunction

   function automatic int step_x(int x, dir_type d);
      case (d)
         DIR_EAST: return x + 1;
         DIR_WEST: return x - 1;
         default:  return x;
      endcase
   endfunction

   function automatic int step_y(int y, dir_type d);
      case (d)
         DIR_SOUTH: return y + 1;
         DIR_NORTH: return y - 1;
         default:   return y;
      endcase
   endfunction

   // off-grid neighbors count as already visited
   function automatic bit is_seen(maze_state_type m, int x, int y);
      if (x < 0 || x >= GW || y < 0 || y >= GH) return 1'b1;
      return m.seen[cell_at(x, y)];
   endfunction

   function automatic maze_state_type fresh_maze(int sx, int sy);
      maze_state_type m;
      int i;
      m = '0;
      for (i = 0; i < CELLS; i++) m.walls[i] = WALLS_ALL;
      m.cx = 4'(sx);
      m.cy = 4'(sy);
      m.seen[cell_at(sx, sy)] = 1'b1;
      m.count = 9'd1;
      return m;
   endfunction

   function automatic maze_state_type carve_step(maze_state_type m, dir_type d, int jx, int jy);
      int  tx, ty, here, there, top, k;
      bit  any_free;
      if (m.done) return m;
      if (m.count >= CELLS) begin
         m.done = 1'b1;
         m.walls[cell_at(GW / 2, 0)][WALL_TOP] = 1'b0;
         m.walls[cell_at(GW / 2, GH - 1)][WALL_BOTTOM] = 1'b0;
         m.walls[cell_at(0, GH / 2)][WALL_LEFT] = 1'b0;
         m.walls[cell_at(GW - 1, GH / 2)][WALL_RIGHT] = 1'b0;
         return m;
      end
      any_free = 1'b0;
      for (k = 0; k < 4; k++)
         if (!is_seen(m, step_x(m.cx, dir_type'(k)), step_y(m.cy, dir_type'(k))))
            any_free = 1'b1;
      if (any_free) begin
         tx = step_x(m.cx, d);
         ty = step_y(m.cy, d);
         // named neighbor already taken: nothing changes
         if (is_seen(m, tx, ty)) return m;
         here = cell_at(m.cx, m.cy);
         there = cell_at(tx, ty);
         if (m.sp < CELLS) begin
            m.stack[m.sp[7:0]] = 8'(here);
            m.sp = m.sp + 9'd1;
         end
         case (d)
            DIR_EAST: begin
               m.walls[here][WALL_RIGHT] = 1'b0;
               m.walls[there][WALL_LEFT] = 1'b0;
            end
            DIR_WEST: begin
               m.walls[here][WALL_LEFT] = 1'b0;
               m.walls[there][WALL_RIGHT] = 1'b0;
            end
            DIR_SOUTH: begin
               m.walls[here][WALL_BOTTOM] = 1'b0;
               m.walls[there][WALL_TOP] = 1'b0;
            end
            default: begin
               m.walls[here][WALL_TOP] = 1'b0;
               m.walls[there][WALL_BOTTOM] = 1'b0;
            end
         endcase
         m.cx = 4'(tx);
         m.cy = 4'(ty);
         m.seen[there] = 1'b1;
         m.count = m.count + 9'd1;
      end else if (m.sp != 0) begin
         m.sp = m.sp - 9'd1;
         top = m.stack[m.sp[7:0]];
         m.cx = 4'(top % GW);
         m.cy = 4'(top / GW);
      end else if (!is_seen(m, jx, jy)) begin
         m.cx = 4'(jx);
         m.cy = 4'(jy);
         m.seen[cell_at(jx, jy)] = 1'b1;
         m.count = m.count + 9'd1;
      end
      return m;
   endfunction

   function automatic maze_state_type maze_advance(maze_state_type m, maze_req_type r);
      case (r.op)
         OP_STEP:    m = carve_step(m, r.dir, r.x, r.y);
         OP_RESTART: m = fresh_maze(r.x, r.y);
         default:    ;
      endcase
      return m;
   endfunction

   function automatic maze_rsp_type maze_report(maze_state_type m, maze_req_type r);
      maze_rsp_type o;
      int        idx;
      idx = (r.op == OP_READ) ? cell_at(r.x, r.y) : cell_at(m.cx, m.cy);
      o.pos_x = m.cx;
      o.pos_y = m.cy;
      o.finished = m.done;
      o.top = m.walls[idx][WALL_TOP];
      o.bottom = m.walls[idx][WALL_BOTTOM];
      o.left = m.walls[idx][WALL_LEFT];
      o.right = m.walls[idx][WALL_RIGHT];
      o.visited = m.seen[idx];
      return o;
   endfunction

   function automatic string rsp_text(maze_rsp_type r);
      return $sformatf("pos=(%0d,%0d) fin=%b top=%b bot=%b left=%b right=%b vis=%b",
                       r.pos_x, r.pos_y, r.finished, r.top, r.bottom, r.left, r.right,
                       r.visited);
   endfunction

   // pick a direction toward an unvisited neighbor when there is one
   function automatic dir_type free_dir(maze_state_type m);
      dir_type opts[$];
      int      k;
      for (k = 0; k < 4; k++)
         if (!is_seen(m, step_x(m.cx, dir_type'(k)), step_y(m.cy, dir_type'(k))))
            opts.insert(opts.size(), dir_type'(k));
      if (opts.size() == 0) return dir_type'($urandom_range(0, 3));
      return opts[$urandom_range(0, opts.size() - 1)];
   endfunction

   task automatic plan_item(opcode_type op, dir_type d, int x, int y);
      maze_req_type r;
      r.op = op;
      r.dir = d;
      r.x = 4'(x);
      r.y = 4'(y);
      pend_items.insert(pend_items.size(), r);
      plan = maze_advance(plan, r);
   endtask

   always @(negedge clock) begin : drive_proc
      maze_req_type r;
      bit        may_idle;
      may_idle = pend_items.size() > TAIL && (n_sent % 160) >= 40;
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pend_items.size() == 0) begin
               req_valid <= 1'b0;
            end else if (may_idle && $urandom_range(0, 3) == 0) begin
               send_gap <= $urandom_range(0, 4);
               req_valid <= 1'b0;
            end else begin
               r = pend_items.pop_front();
               req_opcode <= r.op;
               req_rand_dir <= r.dir;
               req_cell_x <= r.x;
               req_cell_y <= r.y;
               req_valid <= 1'b1;
               n_sent <= n_sent + 1;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else if (may_idle && $urandom_range(0, 3) == 0) begin
            rsp_gap <= $urandom_range(0, 4);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watch_proc
      maze_req_type r;
      maze_rsp_type got;
      maze_rsp_type want;
      if (reset) begin
         model = fresh_maze(0, 0);
         req_taken <= 1'b0;
         stall_cycles = 0;
      end else begin
         // check the finished transfer before predicting a new one
         if (rsp_valid && rsp_ready) begin
            got = {rsp_pos_x, rsp_pos_y, rsp_finished, rsp_wall_top, rsp_wall_bottom,
                   rsp_wall_left, rsp_wall_right, rsp_cell_visited};
            if (want_q.size() == 0) begin
               errors++;
               if (errors <= MAX_SHOWN)
                  $display("%0t: unexpected result %s", $realtime, rsp_text(got));
            end else begin
               want = want_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= MAX_SHOWN)
                     $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                              $realtime, rsp_text(want), rsp_text(got));
               end
            end
         end
         if (req_valid && req_ready) begin
            r.op = req_opcode;
            r.dir = req_rand_dir;
            r.x = req_cell_x;
            r.y = req_cell_y;
            model = maze_advance(model, r);
            want_q.insert(want_q.size(), maze_report(model, r));
            n_accepted++;
         end
         req_taken <= req_valid && req_ready;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG) begin
               $display("backtracking_maze_generator verification failed");
               $finish;
            end
         end
      end
   end

   initial begin : run_proc
      int limit;
      int n;
      int pick;
      plan = fresh_maze(0, 0);

      plan_item(OP_READ, DIR_EAST, 0, 0);
      plan_item(OP_READ, DIR_NORTH, 15, 15);
      plan_item(OP_NONE, DIR_NORTH, 15, 15);
      plan_item(OP_STEP, DIR_WEST, 0, 0);
      plan_item(OP_STEP, DIR_NORTH, 15, 0);
      plan_item(OP_STEP, DIR_EAST, 0, 0);
      plan_item(OP_STEP, DIR_WEST, 0, 0);
      plan_item(OP_STEP, DIR_SOUTH, 0, 0);
      plan_item(OP_STEP, DIR_NORTH, 0, 0);
      plan_item(OP_READ, DIR_EAST, 1, 0);
      plan_item(OP_RESTART, DIR_EAST, 15, 15);
      plan_item(OP_STEP, DIR_EAST, 0, 0);
      plan_item(OP_STEP, DIR_SOUTH, 0, 0);
      plan_item(OP_STEP, DIR_WEST, 0, 0);
      plan_item(OP_STEP, DIR_NORTH, 0, 0);
      plan_item(OP_READ, DIR_SOUTH, 15, 15);
      plan_item(OP_RESTART, DIR_WEST, 0, 15);
      plan_item(OP_STEP, DIR_NORTH, 0, 0);
      plan_item(OP_READ, DIR_EAST, 15, 0);
      plan_item(OP_RESTART, DIR_SOUTH, 15, 0);
      plan_item(OP_STEP, DIR_EAST, 15, 15);
      plan_item(OP_READ, DIR_WEST, 0, 0);

      // mostly well-formed walks that run to a finished maze; some cut short
      while (pend_items.size() < ITEMS) begin
         plan_item(OP_RESTART, dir_type'($urandom_range(0, 3)), $urandom_range(0, 15),
                   $urandom_range(0, 15));
         limit = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 150) : 100000;
         n = 0;
         while (!plan.done && n < limit && pend_items.size() < ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
               plan_item(OP_READ, dir_type'($urandom_range(0, 3)), $urandom_range(0, 15),
                         $urandom_range(0, 15));
            else if (pick < 10)
               plan_item(OP_NONE, dir_type'($urandom_range(0, 3)), $urandom_range(0, 15),
                         $urandom_range(0, 15));
            else if (pick < 14)
               plan_item(OP_STEP, dir_type'($urandom_range(0, 3)), $urandom_range(0, 15),
                         $urandom_range(0, 15));
            else
               plan_item(OP_STEP, free_dir(plan), $urandom_range(0, 15),
                         $urandom_range(0, 15));
            n++;
         end
         if (plan.done) begin
            plan_item(OP_READ, DIR_EAST, GW / 2, 0);
            plan_item(OP_READ, DIR_WEST, GW / 2, GH - 1);
            plan_item(OP_READ, DIR_SOUTH, 0, GH / 2);
            plan_item(OP_READ, DIR_NORTH, GW - 1, GH / 2);
            plan_item(OP_STEP, dir_type'($urandom_range(0, 3)), $urandom_range(0, 15),
                      $urandom_range(0, 15));
            plan_item(OP_STEP, free_dir(plan), $urandom_range(0, 15), $urandom_range(0, 15));
            plan_item(OP_READ, DIR_EAST, $urandom_range(0, 15), $urandom_range(0, 15));
         end
      end
      total_items = pend_items.size();

      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (n_accepted < total_items || want_q.size() != 0) @(negedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0)
         $display("backtracking_maze_generator verification clean");
      else
         $display("backtracking_maze_generator verification failed");
      $finish;
   end

endmodule
